### rtl/round_robin_slice_scheduler_assert.svh
// Assertion macros shared by the scheduler's checker.
// No dependencies; included by files that assert.
`ifndef ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_SLICE_SCHEDULER_ASSERT_SVH

// Clocked property, masked while reset is held.
`define RRS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked during reset as well.
`define RRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/rrs_pkg.sv
// Types and constants of the round-robin slice scheduler.
// No dependencies; imported by all modules and interfaces except rrs_ram.
package rrs_pkg;

  localparam int ID_W    = 16;
  localparam int BURST_W = 16;
  localparam int Q_W     = 16;
  localparam int TIME_W  = 22;
  localparam int SUM_W   = 28;
  localparam int OP_W    = 2;
  localparam int ST_W    = 3;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [Q_W-1:0]    QUANTUM_RST = Q_W'(1);

  // request operation codes; the fourth code is ignored
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_FULL    = 3'd1,
    ST_SLICE   = 3'd2,
    ST_ALLDONE = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_WAIT_CALC,
    S_ACCUM,
    S_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    add;
    logic    clear;
    logic    scan_start;
    logic    scan;
    logic    hit;
    logic    update;
    logic    wait_calc;
    logic    accum;
    logic    emit;
    status_t status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic chk_valid;
    logic chk_rem_nz;
    logic chk_last;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/rrs_in_if.sv
// Request channel of the scheduler: valid/ready plus request payload.
// Depends on rrs_pkg.
interface rrs_in_if;
  import rrs_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [ID_W-1:0]     proc_id;
  logic [BURST_W-1:0]  burst;

  modport source (output valid, output operation, output proc_id, output burst,
                  input ready);
  modport sink   (input valid, input operation, input proc_id, input burst,
                  output ready);
endinterface

### rtl/rrs_out_if.sv
// Result channel of the scheduler: valid/ready plus result payload.
// Depends on rrs_pkg; CNT_W follows the table depth.
interface rrs_out_if #(parameter int CNT_W = 7);
  import rrs_pkg::*;

  logic               valid;
  logic               ready;
  logic [ST_W-1:0]    status;
  logic [ID_W-1:0]    slice_id;
  logic [TIME_W-1:0]  slice_start;
  logic [TIME_W-1:0]  slice_end;
  logic               finished;
  logic [TIME_W-1:0]  wait_time;
  logic [TIME_W-1:0]  turnaround;
  logic [SUM_W-1:0]   total_wait;
  logic [SUM_W-1:0]   total_turnaround;
  logic [CNT_W-1:0]   count;

  modport source (output valid, output status, output slice_id, output slice_start,
                  output slice_end, output finished, output wait_time,
                  output turnaround, output total_wait, output total_turnaround,
                  output count, input ready);
  modport sink   (input valid, input status, input slice_id, input slice_start,
                  input slice_end, input finished, input wait_time,
                  input turnaround, input total_wait, input total_turnaround,
                  input count, output ready);
endinterface

### rtl/rrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/rrs_datapath.sv
// Scheduler datapath: process table RAM, scan pointers, time and sums,
// result register. Depends on rrs_pkg and rrs_ram.
module rrs_datapath #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rrs_pkg::ctrl_cmd_t                  cmd,
  output rrs_pkg::dp_sts_t                    sts,
  input  logic                                cfg_we,
  input  logic [rrs_pkg::Q_W-1:0]             cfg_wdata,
  input  logic [rrs_pkg::ID_W-1:0]            in_proc_id,
  input  logic [rrs_pkg::BURST_W-1:0]         in_burst,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [rrs_pkg::ST_W-1:0]            out_status,
  output logic [rrs_pkg::ID_W-1:0]            out_slice_id,
  output logic [rrs_pkg::TIME_W-1:0]          out_slice_start,
  output logic [rrs_pkg::TIME_W-1:0]          out_slice_end,
  output logic                                out_finished,
  output logic [rrs_pkg::TIME_W-1:0]          out_wait_time,
  output logic [rrs_pkg::TIME_W-1:0]          out_turnaround,
  output logic [rrs_pkg::SUM_W-1:0]           out_total_wait,
  output logic [rrs_pkg::SUM_W-1:0]           out_total_turnaround,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]    out_count
);
  import rrs_pkg::*;

  localparam int AW     = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int WORD_W = ID_W + 2 * BURST_W;

  // architectural state
  logic [Q_W-1:0]    quantum_r;
  logic [CNT_W-1:0]  count_r;
  logic [AW-1:0]     cursor_r;
  logic [TIME_W-1:0] now_r;
  logic [SUM_W-1:0]  wsum_r;
  logic [SUM_W-1:0]  tsum_r;

  // scan pipeline
  logic [AW-1:0]     scan_idx_r;
  logic [CNT_W-1:0]  scan_j_r;
  logic              chk_valid_r;
  logic [AW-1:0]     chk_idx_r;
  logic              chk_last_r;

  // selected entry and partial results
  logic [ID_W-1:0]    hit_id_r;
  logic [BURST_W-1:0] hit_burst_r;
  logic [BURST_W-1:0] hit_rem_r;
  logic [AW-1:0]      hit_idx_r;
  logic [TIME_W-1:0]  res_start_r;
  logic               res_fin_r;
  logic [TIME_W-1:0]  res_wait_r;

  // result register
  logic               out_valid_r;
  logic [ST_W-1:0]    out_status_r;
  logic [ID_W-1:0]    out_id_r;
  logic [TIME_W-1:0]  out_start_r;
  logic [TIME_W-1:0]  out_end_r;
  logic               out_fin_r;
  logic [TIME_W-1:0]  out_wait_r;
  logic [TIME_W-1:0]  out_turn_r;
  logic [SUM_W-1:0]   out_wsum_r;
  logic [SUM_W-1:0]   out_tsum_r;
  logic [CNT_W-1:0]   out_count_r;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [WORD_W-1:0]  ram_rdata;

  logic [AW-1:0]      scan_first;
  logic [AW-1:0]      scan_idx_inc;
  logic [AW-1:0]      cursor_inc;
  logic [Q_W-1:0]     q_eff;
  logic [BURST_W-1:0] slice_len;
  logic [BURST_W-1:0] rem_new;
  logic [TIME_W:0]    now_sum;
  logic [TIME_W-1:0]  now_new;
  logic [TIME_W-1:0]  burst_ext;
  logic [SUM_W:0]     wsum_sum;
  logic [SUM_W:0]     tsum_sum;
  logic               is_slice;

  rrs_ram #(.WIDTH(WORD_W), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  // word layout: {id, burst, remaining}
  always_comb begin
    ram_we    = cmd.add || cmd.update;
    ram_waddr = cmd.add ? count_r[AW-1:0] : hit_idx_r;
    ram_wdata = cmd.add ? {in_proc_id, in_burst, in_burst}
                        : {hit_id_r, hit_burst_r, rem_new};
    ram_re    = cmd.scan && (scan_j_r < count_r);
  end

  always_comb begin
    scan_first   = (CNT_W'(cursor_r) < count_r) ? cursor_r : '0;
    scan_idx_inc = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == count_r)
                   ? '0 : scan_idx_r + AW'(1);
    cursor_inc   = ((CNT_W'(hit_idx_r) + CNT_W'(1)) >= count_r)
                   ? '0 : hit_idx_r + AW'(1);
    q_eff        = (quantum_r == '0) ? Q_W'(1) : quantum_r;
    slice_len    = (hit_rem_r > q_eff) ? q_eff : hit_rem_r;
    rem_new      = hit_rem_r - slice_len;
    now_sum      = {1'b0, now_r} + (TIME_W + 1)'(slice_len);
    now_new      = now_sum[TIME_W] ? TIME_MAX : now_sum[TIME_W-1:0];
    burst_ext    = TIME_W'(hit_burst_r);
    wsum_sum     = {1'b0, wsum_r} + (SUM_W + 1)'(res_wait_r);
    tsum_sum     = {1'b0, tsum_r} + (SUM_W + 1)'(now_r);
    is_slice     = (cmd.status == ST_SLICE);
  end

  always_comb begin
    sts.full       = (count_r == CNT_W'(MAX_ENTRIES));
    sts.empty      = (count_r == '0);
    sts.chk_valid  = chk_valid_r;
    sts.chk_rem_nz = (ram_rdata[BURST_W-1:0] != '0);
    sts.chk_last   = chk_last_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  // quantum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
    end else if (cfg_we) begin
      quantum_r <= cfg_wdata;
    end
  end

  // table bookkeeping, time and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      cursor_r <= '0;
      now_r    <= '0;
      wsum_r   <= '0;
      tsum_r   <= '0;
    end else begin
      if (cmd.clear) begin
        count_r  <= '0;
        cursor_r <= '0;
        now_r    <= '0;
        wsum_r   <= '0;
        tsum_r   <= '0;
      end
      if (cmd.add) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.update) begin
        now_r    <= now_new;
        cursor_r <= cursor_inc;
      end
      if (cmd.accum && res_fin_r) begin
        wsum_r <= wsum_sum[SUM_W] ? SUM_MAX : wsum_sum[SUM_W-1:0];
        tsum_r <= tsum_sum[SUM_W] ? SUM_MAX : tsum_sum[SUM_W-1:0];
      end
    end
  end

  // scan: one read issued per cycle, checked in the following cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_valid_r <= 1'b0;
    end else if (cmd.scan_start) begin
      chk_valid_r <= 1'b0;
    end else if (cmd.scan) begin
      chk_valid_r <= ram_re;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= scan_first;
      scan_j_r   <= '0;
    end else if (ram_re) begin
      scan_idx_r <= scan_idx_inc;
      scan_j_r   <= scan_j_r + CNT_W'(1);
      chk_idx_r  <= scan_idx_r;
      chk_last_r <= (scan_j_r == count_r - CNT_W'(1));
    end
    if (cmd.hit) begin
      hit_id_r    <= ram_rdata[WORD_W-1 -: ID_W];
      hit_burst_r <= ram_rdata[2*BURST_W-1 -: BURST_W];
      hit_rem_r   <= ram_rdata[BURST_W-1:0];
      hit_idx_r   <= chk_idx_r;
    end
    if (cmd.update) begin
      res_start_r <= now_r;
      res_fin_r   <= (rem_new == '0);
    end
    if (cmd.wait_calc) begin
      res_wait_r <= (now_r >= burst_ext) ? now_r - burst_ext : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_id_r     <= is_slice ? hit_id_r : '0;
      out_start_r  <= is_slice ? res_start_r : '0;
      out_end_r    <= is_slice ? now_r : '0;
      out_fin_r    <= is_slice && res_fin_r;
      out_wait_r   <= (is_slice && res_fin_r) ? res_wait_r : '0;
      out_turn_r   <= (is_slice && res_fin_r) ? now_r : '0;
      out_wsum_r   <= wsum_r;
      out_tsum_r   <= tsum_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_slice_id         = out_id_r;
  assign out_slice_start      = out_start_r;
  assign out_slice_end        = out_end_r;
  assign out_finished         = out_fin_r;
  assign out_wait_time        = out_wait_r;
  assign out_turnaround       = out_turn_r;
  assign out_total_wait       = out_wsum_r;
  assign out_total_turnaround = out_tsum_r;
  assign out_count            = out_count_r;

endmodule

### rtl/rrs_ctrl.sv
// Scheduler controller: request decode and sequencing of the datapath.
// Depends on rrs_pkg.
module rrs_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [rrs_pkg::OP_W-1:0] in_op,
  output logic                    in_ready,
  input  rrs_pkg::dp_sts_t        sts,
  output rrs_pkg::ctrl_cmd_t      cmd
);
  import rrs_pkg::*;

  state_t  state_r, state_nxt;
  status_t status_r, status_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_ADDED;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.status = status_r;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_op)
            OP_ADD: begin
              cmd.add    = !sts.full;
              status_nxt = sts.full ? ST_FULL : ST_ADDED;
              state_nxt  = S_EMIT;
            end
            OP_RUN: begin
              if (sts.empty) begin
                status_nxt = ST_ALLDONE;
                state_nxt  = S_EMIT;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            OP_CLEAR: begin
              cmd.clear  = 1'b1;
              status_nxt = ST_CLEARED;
              state_nxt  = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;  // unused code: dropped, no result
            end
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.chk_valid && sts.chk_rem_nz) begin
          cmd.hit   = 1'b1;
          state_nxt = S_UPDATE;
        end else if (sts.chk_valid && sts.chk_last) begin
          status_nxt = ST_ALLDONE;
          state_nxt  = S_EMIT;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_WAIT_CALC;
      end
      S_WAIT_CALC: begin
        cmd.wait_calc = 1'b1;
        state_nxt     = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.accum  = 1'b1;
        status_nxt = ST_SLICE;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/round_robin_slice_scheduler.sv
// Round-robin slice scheduler. Add requests fill a process table (id, burst)
// held in one RAM; run requests pick the next entry with time left, scanning
// in table order from the cursor with wrap-around, and run it for
// min(remaining, quantum) time units (a quantum of 0 counts as 1). Time and
// the wait/turnaround totals saturate. Clear empties the table and zeroes
// time and totals. Operation code 3 is dropped without a result.
// Add and clear go from accept through the result register back to idle. A
// run reads one table entry per cycle from the single RAM read port, scanning
// until an entry with time left is hit or, after a full scan, reporting
// all-done. A new request is taken
// while the previous result still waits in the output register. The table
// has no reset and no clearing pass; entries are only read after they have
// been written.
// Depends on rrs_pkg, rrs_in_if, rrs_out_if, rrs_ctrl, rrs_datapath.
module round_robin_slice_scheduler #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rrs_in_if.sink                    in_req,
  rrs_out_if.source                 out_rsp,
  input  logic                      cfg_we,
  input  logic [rrs_pkg::Q_W-1:0]   cfg_wdata
);
  import rrs_pkg::*;

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  ctrl_cmd_t        cmd;
  dp_sts_t          sts;
  logic [CNT_W-1:0] count;

  // controller: request decode, scan/update sequencing, result hand-off
  rrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_op    (in_req.operation),
    .in_ready (in_req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: table RAM, time, totals, result register
  rrs_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_proc_id           (in_req.proc_id),
    .in_burst             (in_req.burst),
    .out_ready            (out_rsp.ready),
    .out_valid            (out_rsp.valid),
    .out_status           (out_rsp.status),
    .out_slice_id         (out_rsp.slice_id),
    .out_slice_start      (out_rsp.slice_start),
    .out_slice_end        (out_rsp.slice_end),
    .out_finished         (out_rsp.finished),
    .out_wait_time        (out_rsp.wait_time),
    .out_turnaround       (out_rsp.turnaround),
    .out_total_wait       (out_rsp.total_wait),
    .out_total_turnaround (out_rsp.total_turnaround),
    .out_count            (count)
  );

  // count is resized to the result interface's count width
  assign out_rsp.count = $bits(out_rsp.count)'(count);

endmodule

### rtl/rrs_checker.sv
// Port-level checker for the round-robin slice scheduler, bound to the top.
// Depends on rrs_pkg and round_robin_slice_scheduler_assert.svh.
`include "round_robin_slice_scheduler_assert.svh"

module rrs_checker #(
  parameter int MAX_ENTRIES = 64
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [rrs_pkg::ST_W-1:0]         status,
  input logic [rrs_pkg::ID_W-1:0]         slice_id,
  input logic [rrs_pkg::TIME_W-1:0]       slice_start,
  input logic [rrs_pkg::TIME_W-1:0]       slice_end,
  input logic                             finished,
  input logic [rrs_pkg::TIME_W-1:0]       wait_time,
  input logic [rrs_pkg::TIME_W-1:0]       turnaround,
  input logic [$clog2(MAX_ENTRIES+1)-1:0] count
);
  import rrs_pkg::*;

  // a stalled result keeps its status, slice end and count
  `RRS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slice_end) && $stable(count), "result changed while stalled")

  // slice fields are zero unless a slice ran
  `RRS_ASSERT(a_noslice_zero, clk, rst_n, out_valid && status != ST_SLICE |-> slice_id == '0 && slice_start == '0 && slice_end == '0 && !finished && wait_time == '0, "slice fields set without a slice")

  // a finish ends at its turnaround and never waits longer than that
  `RRS_ASSERT(a_finish_times, clk, rst_n, out_valid && finished |-> turnaround == slice_end && wait_time <= turnaround && status == ST_SLICE, "inconsistent finish times")

  // time never runs backward within a slice; table never overfills
  `RRS_ASSERT(a_slice_order, clk, rst_n, out_valid |-> slice_start <= slice_end && count <= ($bits(count))'(MAX_ENTRIES), "slice order or count out of range")

endmodule

bind round_robin_slice_scheduler rrs_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_rrs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .status      (out_rsp.status),
  .slice_id    (out_rsp.slice_id),
  .slice_start (out_rsp.slice_start),
  .slice_end   (out_rsp.slice_end),
  .finished    (out_rsp.finished),
  .wait_time   (out_rsp.wait_time),
  .turnaround  (out_rsp.turnaround),
  .count       (count)
);
